// ----- hw/rtl/rfb_pkg.sv -----
`default_nettype none

package rfb_pkg;

  // Frame geometry
  localparam int unsigned FrameLen = 23;
  localparam int unsigned CrcSpan  = 21;
  localparam int unsigned IdxW     = 5;

  localparam logic [IdxW-1:0] LastIdx  = IdxW'(FrameLen - 1);
  localparam logic [IdxW-1:0] CrcHiPos = IdxW'(CrcSpan);
  localparam logic [IdxW-1:0] CrcLoPos = IdxW'(CrcSpan + 1);

  // Header and payload positions
  localparam logic [IdxW-1:0] PosStart     = 5'd0;
  localparam logic [IdxW-1:0] PosDevId     = 5'd1;
  localparam logic [IdxW-1:0] PosDevType   = 5'd2;
  localparam logic [IdxW-1:0] PosCmdEcho   = 5'd3;
  localparam logic [IdxW-1:0] PosLenLo     = 5'd6;
  localparam logic [IdxW-1:0] PosSecLo     = 5'd7;
  localparam logic [IdxW-1:0] PosSecHi     = 5'd8;
  localparam logic [IdxW-1:0] PosDistLo    = 5'd13;
  localparam logic [IdxW-1:0] PosDistHi    = 5'd14;
  localparam logic [IdxW-1:0] PosIntensLo  = 5'd17;
  localparam logic [IdxW-1:0] PosIntensHi  = 5'd18;

  // Fixed byte values
  localparam logic [7:0]  StartByte  = 8'hA5;
  localparam logic [7:0]  CmdEcho    = 8'h01;
  localparam logic [7:0]  LenByte    = 8'h0E;
  localparam logic [7:0]  NoTarget   = 8'hFF;
  localparam logic [15:0] OutOfRange = 16'hFFFF;
  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [15:0] CrcPoly    = 16'hA001;

  // Register reset values
  localparam logic [15:0] MaxRangeRst  = 16'd20000;
  localparam logic [7:0]  DevIdRst     = 8'd3;
  localparam logic [7:0]  DevTypeRst   = 8'd32;
  localparam logic [15:0] IntensRst    = 16'd10000;

  typedef enum logic [1:0] {
    CfgMaxRange  = 2'd0,
    CfgDeviceId  = 2'd1,
    CfgDevType   = 2'd2,
    CfgIntensity = 2'd3
  } rfb_cfg_idx_t;

  typedef struct packed {
    logic [15:0] max_range_mm;
    logic [7:0]  device_id;
    logic [7:0]  device_type;
    logic [15:0] primary_intensity;
  } rfb_cfg_t;

  // One latched distance waiting for the serializer
  typedef struct packed {
    logic        valid;
    logic [15:0] distance;
  } rfb_item_t;

  // CRC-16/MODBUS update over one byte, reflected
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Data byte at a frame position covered by the CRC
  function automatic logic [7:0] frame_data_byte(input logic [IdxW-1:0] pos,
                                                 input logic [15:0] distance,
                                                 input rfb_cfg_t cfg);
    logic [7:0] b;
    case (pos)
      PosStart:    b = StartByte;
      PosDevId:    b = cfg.device_id;
      PosDevType:  b = cfg.device_type;
      PosCmdEcho:  b = CmdEcho;
      PosLenLo:    b = LenByte;
      PosSecLo:    b = NoTarget;
      PosSecHi:    b = NoTarget;
      PosDistLo:   b = distance[7:0];
      PosDistHi:   b = distance[15:8];
      PosIntensLo: b = cfg.primary_intensity[7:0];
      PosIntensHi: b = cfg.primary_intensity[15:8];
      default:     b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rangefinder_frame_builder.sv -----
// Each altitude waits in the input register until the serializer takes it into its frame state.
// The output register sends one byte per cycle while out_ready is high; the next altitude
//   waits in the input register while the current frame drains.
// Reset (synchronous, rst_n low): pipeline empty, CRC at 0xFFFF, registers at
//   max_range 20000, device id 3, device type 32, intensity 10000.
`default_nettype none

module rangefinder_frame_builder
  import rfb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [19:0] in_altitude_mm,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_frame_byte,
  output logic             out_last_byte,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  rfb_cfg_t  cfg_r, cfg_nxt;
  rfb_item_t item;
  logic      take;

  // Decode configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (rfb_cfg_idx_t'(cfg_index))
        CfgMaxRange:  cfg_nxt.max_range_mm      = cfg_wdata;
        CfgDeviceId:  cfg_nxt.device_id         = cfg_wdata[7:0];
        CfgDevType:   cfg_nxt.device_type       = cfg_wdata[7:0];
        CfgIntensity: cfg_nxt.primary_intensity = cfg_wdata;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_range_mm      <= MaxRangeRst;
      cfg_r.device_id         <= DevIdRst;
      cfg_r.device_type       <= DevTypeRst;
      cfg_r.primary_intensity <= IntensRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rfb_input_stage u_input (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_altitude_mm (in_altitude_mm),
    .max_range_mm   (cfg_r.max_range_mm),
    .take           (take),
    .item           (item)
  );

  rfb_serializer u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .item           (item),
    .cfg            (cfg_r),
    .take           (take),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/rfb_input_stage.sv -----
`default_nettype none

module rfb_input_stage
  import rfb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [19:0] in_altitude_mm,
  input  wire logic [15:0] max_range_mm,
  input  wire logic        take,
  output rfb_item_t        item
);

  logic        pend_valid_r, pend_valid_nxt;
  logic [15:0] pend_dist_r, pend_dist_nxt;
  logic [15:0] sat_dist;
  logic        accept;

  // Saturate distances beyond the range limit or beyond sixteen bits
  always_comb begin
    if (in_altitude_mm > {4'h0, max_range_mm} || in_altitude_mm > {4'h0, OutOfRange}) begin
      sat_dist = OutOfRange;
    end else begin
      sat_dist = in_altitude_mm[15:0];
    end
  end

  assign in_ready = !pend_valid_r || take;
  assign accept   = in_valid && in_ready;

  // Hold one pending transaction until the serializer takes it
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_dist_nxt  = pend_dist_r;
    if (take) begin
      pend_valid_nxt = 1'b0;
    end
    if (accept) begin
      pend_valid_nxt = 1'b1;
      pend_dist_nxt  = sat_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
    end
    pend_dist_r <= pend_dist_nxt;
  end

  assign item.valid    = pend_valid_r;
  assign item.distance = pend_dist_r;

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> pend_valid_r)
    else $error("accepted transaction not held");
  a_take_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> pend_valid_r)
    else $error("serializer took an empty slot");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/rfb_serializer.sv -----
`default_nettype none

module rfb_serializer
  import rfb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  rfb_item_t       item,
  input  rfb_cfg_t        cfg,
  output logic            take,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_frame_byte,
  output logic            out_last_byte
);

  logic            busy_r, busy_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic [15:0]     dist_r, dist_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_byte_r, out_byte_nxt;
  logic            out_last_r, out_last_nxt;

  logic       advance;
  logic       emit;
  logic       at_end;
  logic [7:0] cur_byte;

  assign advance = !out_valid_r || out_ready;
  assign emit    = advance && busy_r;
  assign at_end  = busy_r && (idx_r == LastIdx);
  assign take    = item.valid && (!busy_r || (advance && at_end));

  // Select the byte at the current frame position
  always_comb begin
    case (idx_r)
      CrcHiPos: cur_byte = crc_r[15:8];
      CrcLoPos: cur_byte = crc_r[7:0];
      default:  cur_byte = frame_data_byte(idx_r, dist_r, cfg);
    endcase
  end

  // Advance the frame, fold data bytes into the CRC, load the next distance
  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    dist_nxt      = dist_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_byte;
      out_last_nxt  = at_end;
      idx_nxt       = idx_r + IdxW'(1);
      if (idx_r < CrcHiPos) begin
        crc_nxt = crc_update(crc_r, cur_byte);
      end
      // Return to idle with the CRC back at its initial value, unless a new distance is taken
      if (at_end) begin
        busy_nxt = 1'b0;
        idx_nxt  = '0;
        crc_nxt  = CrcInit;
      end
    end else if (advance) begin
      out_valid_nxt = 1'b0;
      out_last_nxt  = 1'b0;
    end
    if (take) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      crc_nxt  = CrcInit;
      dist_nxt = item.distance;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      crc_r       <= CrcInit;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
    dist_r     <= dist_nxt;
    out_byte_r <= out_byte_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last_byte  = out_last_r;

`ifndef SYNTHESIS
  a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= LastIdx)
    else $error("frame index past last byte");
  a_stall_holds_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(idx_r) && $stable(crc_r))
    else $error("frame advanced during output stall");
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && at_end) |=> (out_valid_r && out_last_r))
    else $error("last byte not flagged");
  a_last_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_r |-> out_valid_r)
    else $error("last flag without valid byte");
`endif

endmodule

`default_nettype wire
